>>> design/ihre_pkg.sv
// Shared types, constants and helpers for the Intel HEX record encoder.
// No dependencies; imported by every module of the block but ihre_checker.
`default_nettype none

package ihre_pkg;

    localparam int MAX_RECORD_BYTES_DEF = 32;
    localparam int CNT_W                = 6;
    localparam int CFG_ADDR_W           = 3;

    localparam logic [CNT_W-1:0] RECORD_BYTES_RST = 6'd32;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    localparam logic REG_START_ADDRESS = 1'b0;
    localparam logic REG_RECORD_BYTES  = 1'b1;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
    localparam logic [7:0] REC_TYPE_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN       = 8'h02;
    localparam logic [7:0] EOF_CSUM      = 8'hFF;

    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h37;

    typedef enum logic {
        JOB_DATA,
        JOB_EOF
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [31:0]      addr;
        logic [7:0]       dsum;
    } job_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] idx;
        logic [7:0]       data;
    } buf_wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } release_t;

    typedef enum logic [1:0] {
        REC_DATA,
        REC_EXT,
        REC_EOF
    } rec_mode_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COLON,
        BK_HDR,
        BK_DATA,
        BK_CSUM,
        BK_CR,
        BK_LF
    } back_state_t;

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        logic [6:0] ext;
        ext = {3'b000, v};
        if (v < 4'd10)
        begin
            return CH_ZERO + ext;
        end
        return CH_ALPHA + ext;
    endfunction

endpackage

`default_nettype wire

>>> design/ihre_front.sv
// Front end: configuration registers, input acceptance, record buffering control.
// Depends on ihre_pkg; feeds ihre_queue and the buffer write port of ihre_back.
`default_nettype none

module ihre_front
    import ihre_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output job_t                  job,
    output logic                  job_push,
    input  logic                  job_full,
    output buf_wr_t               buf_wr,
    input  release_t              rel
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORD_BYTES);

    logic [31:0]      start_address_reg;
    logic [CNT_W-1:0] record_bytes_reg;
    logic [31:0]      running_addr_reg, running_addr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [7:0]       sum_reg, sum_next;
    logic             cur_bank_reg, cur_bank_next;
    logic [1:0]       bank_busy_reg, bank_busy_next;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] fill_inc;
    logic [7:0]       sum_inc;
    logic             cfg_wr;
    logic             accept;
    logic             is_data;
    logic             close_rec;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !job_full && !bank_busy_reg[cur_bank_reg];
    assign accept   = s_tvalid && s_tready;
    assign is_data  = (s_tuser == OP_DATA);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign sum_inc  = sum_reg + s_tdata;

    always_comb
    begin
        if (record_bytes_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (record_bytes_reg > MAX_CNT)
        begin
            limit = MAX_CNT;
        end
        else
        begin
            limit = record_bytes_reg;
        end
    end

    assign close_rec = (fill_inc >= limit) || s_tlast;

    always_comb
    begin
        unique case (paddr[CFG_ADDR_W-1])
            REG_START_ADDRESS: prdata = start_address_reg;
            REG_RECORD_BYTES:  prdata = {26'd0, record_bytes_reg};
        endcase
    end

    assign buf_wr.en   = accept && is_data;
    assign buf_wr.bank = cur_bank_reg;
    assign buf_wr.idx  = fill_reg;
    assign buf_wr.data = s_tdata;

    assign job_push  = accept && (!is_data || close_rec);
    assign job.kind  = is_data ? JOB_DATA : JOB_EOF;
    assign job.bank  = cur_bank_reg;
    assign job.count = is_data ? fill_inc : '0;
    assign job.addr  = running_addr_reg;
    assign job.dsum  = sum_inc;

    always_comb
    begin
        running_addr_next = running_addr_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        cur_bank_next     = cur_bank_reg;
        bank_busy_next    = bank_busy_reg;
        if (rel.en)
        begin
            bank_busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (!is_data)
            begin
                fill_next = '0;
                sum_next  = '0;
            end
            else if (close_rec)
            begin
                fill_next                      = '0;
                sum_next                       = '0;
                running_addr_next              = running_addr_reg + 32'(fill_inc);
                cur_bank_next                  = !cur_bank_reg;
                bank_busy_next[cur_bank_reg]   = 1'b1;
            end
            else
            begin
                fill_next = fill_inc;
                sum_next  = sum_inc;
            end
        end
        if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_START_ADDRESS)
        begin
            running_addr_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
            record_bytes_reg  <= RECORD_BYTES_RST;
            running_addr_reg  <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            cur_bank_reg      <= 1'b0;
            bank_busy_reg     <= '0;
        end
        else
        begin
            running_addr_reg <= running_addr_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            cur_bank_reg     <= cur_bank_next;
            bank_busy_reg    <= bank_busy_next;
            if (cfg_wr)
            begin
                unique case (paddr[CFG_ADDR_W-1])
                    REG_START_ADDRESS: start_address_reg <= pwdata;
                    REG_RECORD_BYTES:  record_bytes_reg  <= pwdata[CNT_W-1:0];
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ihre_queue.sv
// Two-entry job queue between front end and character sequencer.
// Depends on ihre_pkg for the job type.
`default_nettype none

module ihre_queue
    import ihre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

>>> design/ihre_back.sv
// Back end: two-bank record buffer and the record character sequencer.
// Depends on ihre_pkg; takes jobs from ihre_queue, feeds ihre_pack.
`default_nettype none

module ihre_back
    import ihre_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    input  buf_wr_t    buf_wr,
    output release_t   rel,
    output logic       c_valid,
    output logic [6:0] c_char,
    output logic       c_last,
    input  logic       c_ready
);

    localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

    logic [7:0] buf_mem [2 * (2 ** IDX_W)];
    logic [7:0] rd_data_reg;
    logic [IDX_W:0] rd_addr;

    back_state_t      state_reg, state_next;
    rec_mode_t        mode_reg, mode_next;
    logic             nib_reg, nib_next;
    logic [2:0]       idx_reg, idx_next;
    logic [IDX_W-1:0] data_idx_reg, data_idx_next;
    logic             ext_reg, ext_next;
    logic [CNT_W-1:0] n_reg;
    logic [31:0]      addr_reg;
    logic [7:0]       dsum_reg;
    logic             bank_reg;
    logic [15:0]      new_hi_reg;

    logic [IDX_W-1:0] data_idx_inc;
    logic [CNT_W-1:0] data_pos;
    logic             data_last;
    logic [2:0]       hdr_last;
    logic [7:0]       hdr_byte;
    logic [7:0]       sum_data;
    logic [7:0]       sum_ext;
    logic [7:0]       csum;
    logic [7:0]       cur_byte;
    logic [31:0]      next_addr;
    logic             adv;
    logic             start;

    assign data_idx_inc = data_idx_reg + IDX_W'(1);
    assign data_pos     = CNT_W'(data_idx_reg) + CNT_W'(1);
    assign data_last    = (data_pos == n_reg);
    assign hdr_last     = (mode_reg == REC_EXT) ? 3'd5 : 3'd3;
    assign adv          = c_ready && (state_reg != BK_IDLE);
    assign start        = (state_reg == BK_IDLE) && job_valid;
    assign next_addr    = job.addr + 32'(job.count);

    assign rd_addr = {bank_reg, (state_reg == BK_DATA && nib_reg && adv) ?
                                data_idx_inc : data_idx_reg};

    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            buf_mem[{buf_wr.bank, buf_wr.idx[IDX_W-1:0]}] <= buf_wr.data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    always_comb
    begin
        hdr_byte = 8'h00;
        unique case (mode_reg)
            REC_DATA:
            begin
                case (idx_reg)
                    3'd0:    hdr_byte = {2'b00, n_reg};
                    3'd1:    hdr_byte = addr_reg[15:8];
                    3'd2:    hdr_byte = addr_reg[7:0];
                    default: hdr_byte = REC_TYPE_DATA;
                endcase
            end
            REC_EXT:
            begin
                case (idx_reg)
                    3'd0:    hdr_byte = EXT_LEN;
                    3'd3:    hdr_byte = REC_TYPE_EXT;
                    3'd4:    hdr_byte = new_hi_reg[15:8];
                    3'd5:    hdr_byte = new_hi_reg[7:0];
                    default: hdr_byte = 8'h00;
                endcase
            end
            REC_EOF:
            begin
                case (idx_reg)
                    3'd3:    hdr_byte = REC_TYPE_EOF;
                    default: hdr_byte = 8'h00;
                endcase
            end
            default: hdr_byte = 8'h00;
        endcase
    end

    assign sum_data = {2'b00, n_reg} + addr_reg[15:8] + addr_reg[7:0] + dsum_reg;
    assign sum_ext  = EXT_LEN + REC_TYPE_EXT + new_hi_reg[15:8] + new_hi_reg[7:0];

    always_comb
    begin
        unique case (mode_reg)
            REC_DATA: csum = 8'h00 - sum_data;
            REC_EXT:  csum = 8'h00 - sum_ext;
            REC_EOF:  csum = EOF_CSUM;
            default:  csum = EOF_CSUM;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            BK_HDR:  cur_byte = hdr_byte;
            BK_DATA: cur_byte = rd_data_reg;
            default: cur_byte = csum;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_COLON;
                end
            end
            BK_COLON:
            begin
                if (adv)
                begin
                    state_next = BK_HDR;
                end
            end
            BK_HDR:
            begin
                if (adv && nib_reg && idx_reg == hdr_last)
                begin
                    state_next = (mode_reg == REC_DATA) ? BK_DATA : BK_CSUM;
                end
            end
            BK_DATA:
            begin
                if (adv && nib_reg && data_last)
                begin
                    state_next = BK_CSUM;
                end
            end
            BK_CSUM:
            begin
                if (adv && nib_reg)
                begin
                    state_next = BK_CR;
                end
            end
            BK_CR:
            begin
                if (adv)
                begin
                    state_next = BK_LF;
                end
            end
            BK_LF:
            begin
                if (adv)
                begin
                    state_next = (mode_reg == REC_DATA && ext_reg) ? BK_COLON : BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        nib_next      = nib_reg;
        idx_next      = idx_reg;
        data_idx_next = data_idx_reg;
        ext_next      = ext_reg;
        if (start)
        begin
            mode_next     = (job.kind == JOB_EOF) ? REC_EOF : REC_DATA;
            ext_next      = (job.kind == JOB_DATA) && (job.addr[31:16] != next_addr[31:16]);
            nib_next      = 1'b0;
            idx_next      = 3'd0;
            data_idx_next = '0;
        end
        else if (adv)
        begin
            if (state_reg == BK_HDR || state_reg == BK_DATA || state_reg == BK_CSUM)
            begin
                nib_next = !nib_reg;
            end
            else
            begin
                nib_next = 1'b0;
            end
            if (state_reg == BK_COLON)
            begin
                idx_next      = 3'd0;
                data_idx_next = '0;
            end
            if (state_reg == BK_HDR && nib_reg)
            begin
                idx_next = idx_reg + 3'd1;
            end
            if (state_reg == BK_DATA && nib_reg)
            begin
                data_idx_next = data_idx_inc;
            end
            if (state_reg == BK_LF && mode_reg == REC_DATA && ext_reg)
            begin
                mode_next = REC_EXT;
            end
        end
    end

    // outputs
    always_comb
    begin
        job_pop  = start;
        c_valid  = (state_reg != BK_IDLE);
        rel.en   = (state_reg == BK_LF) && adv && (mode_reg == REC_DATA);
        rel.bank = bank_reg;
        c_last   = (state_reg == BK_LF) && !(mode_reg == REC_DATA && ext_reg);
        unique case (state_reg)
            BK_COLON: c_char = CH_COLON;
            BK_CR:    c_char = CH_CR;
            BK_LF:    c_char = CH_LF;
            default:  c_char = hex_char(nib_reg ? cur_byte[3:0] : cur_byte[7:4]);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            mode_reg     <= REC_DATA;
            nib_reg      <= 1'b0;
            idx_reg      <= 3'd0;
            data_idx_reg <= '0;
            ext_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            nib_reg      <= nib_next;
            idx_reg      <= idx_next;
            data_idx_reg <= data_idx_next;
            ext_reg      <= ext_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg      <= job.count;
            addr_reg   <= job.addr;
            dsum_reg   <= job.dsum;
            bank_reg   <= job.bank;
            new_hi_reg <= next_addr[31:16];
        end
    end

endmodule

`default_nettype wire

>>> design/ihre_pack.sv
// Character packer: pairs the character stream into output transactions; a lone last character goes alone.
// Depends on ihre_pkg; drives the master-side stream ports.
`default_nettype none

module ihre_pack
    import ihre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        c_valid,
    input  logic [6:0]  c_char,
    input  logic        c_last,
    output logic        c_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic       hold_valid_reg;
    logic [6:0] hold_char_reg;
    logic       out_valid_reg;
    logic [6:0] out_first_reg;
    logic [6:0] out_second_reg;
    logic [1:0] out_count_reg;
    logic       out_last_reg;
    logic       take;
    logic       load;

    assign c_ready  = !out_valid_reg || m_tready;
    assign take     = c_valid && c_ready;
    assign load     = take && (hold_valid_reg || c_last);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_second_reg, out_first_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                hold_valid_reg <= !hold_valid_reg && !c_last;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !hold_valid_reg)
        begin
            hold_char_reg <= c_char;
        end
        if (load)
        begin
            out_last_reg <= c_last;
            if (hold_valid_reg)
            begin
                out_first_reg  <= hold_char_reg;
                out_second_reg <= c_char;
                out_count_reg  <= 2'd2;
            end
            else
            begin
                out_first_reg  <= c_char;
                out_second_reg <= 7'd0;
                out_count_reg  <= 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/intel_hex_record_encoder_top.sv
// Intel HEX record encoder, top level. The sequencer in ihre_back makes one character per
// cycle while the packer takes it (c_ready). It sends data and end-of-file records, adds an
// extended address record after a data record that crosses a 64K boundary, and returns to
// its idle state between jobs.
// Reset is asynchronous, active low; it clears control state, the buffer is not cleared.
// Depends on ihre_pkg, ihre_front, ihre_queue, ihre_back, ihre_pack.
`default_nettype none

module intel_hex_record_encoder_top
    import ihre_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] opcode
    input  logic                  s_tlast,   // chunk_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [6:0] char_first, [13:7] char_second,
                                             // [15:14] pair_count
    output logic                  m_tlast    // last_of_run
);

    job_t       push_job;
    job_t       head_job;
    logic       job_push;
    logic       job_full;
    logic       job_pop;
    logic       job_valid;
    buf_wr_t    buf_wr;
    release_t   rel;
    logic       c_valid;
    logic [6:0] c_char;
    logic       c_last;
    logic       c_ready;

    ihre_front #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .job      (push_job),
        .job_push (job_push),
        .job_full (job_full),
        .buf_wr   (buf_wr),
        .rel      (rel)
    );

    ihre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .valid    (job_valid),
        .head     (head_job)
    );

    ihre_back #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .buf_wr    (buf_wr),
        .rel       (rel),
        .c_valid   (c_valid),
        .c_char    (c_char),
        .c_last    (c_last),
        .c_ready   (c_ready)
    );

    ihre_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .c_valid  (c_valid),
        .c_char   (c_char),
        .c_last   (c_last),
        .c_ready  (c_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/ihre_checker.sv
// Port-level checks on the output stream of the Intel HEX record encoder.
// Depends on intel_hex_record_encoder_top, to which it is bound below.
`default_nettype none

module ihre_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:14] == 2'd1 || m_tdata[15:14] == 2'd2))
        else $error("pair_count out of range");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:14] == 2'd1 |-> m_tlast)
        else $error("single character before end of run");

    a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:14] == 2'd1 |-> m_tdata[13:7] == 7'd0)
        else $error("second character not cleared on single-character transaction");

endmodule

bind intel_hex_record_encoder_top ihre_checker u_ihre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/intel_hex_record_encoder_top_tb.sv
// Testbench for intel_hex_record_encoder_top: drives bytes and end markers on the input
// stream, predicts the HEX text pairs in-bench and checks every output transaction.
// Depends on ihre_pkg and the encoder RTL only.

module intel_hex_record_encoder_top_tb;
    import ihre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REC     = 32;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 300;
    localparam string HEX_DIGITS = "0123456789ABCDEF";

    typedef struct packed {
        logic       last;
        logic [1:0] cnt;
        logic [6:0] second;
        logic [6:0] first;
    } hex_pair_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_START,
        ROW_SET_SIZE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        op;
        logic [7:0]  b;
        logic        ce;
        logic [31:0] val;
        string       line;
    } row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] data_byte
    logic                  s_tuser  = 1'b0; // [0] opcode
    logic                  s_tlast  = 1'b0; // chunk_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [6:0] first, [13:7] second, [15:14] count
    logic                  m_tlast;         // last_of_run

    // encoder state mirror
    logic [7:0]  rec_buf [MAX_REC];
    logic [5:0]  rec_fill      = '0;
    logic [31:0] rec_addr      = '0;
    logic [7:0]  rec_sum       = '0;
    logic [31:0] cfg_start     = '0;
    logic [5:0]  cfg_rec_bytes = RECORD_BYTES_RST;

    logic [7:0] hex_text [$];
    hex_pair_t  pending_pairs [$];

    int   errors        = 0;
    int   items_sent    = 0;
    int   pairs_checked = 0;
    int   send_idle_pct = 12;
    int   rcv_idle_pct  = 63;
    logic hold_go       = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    row_t dir_rows [26];

    intel_hex_record_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] size_limit();
        if (cfg_rec_bytes == 6'd0)
        begin
            return 6'd1;
        end
        if (cfg_rec_bytes > MAX_REC)
        begin
            return 6'(MAX_REC);
        end
        return cfg_rec_bytes;
    endfunction

    function automatic void put_hex(input logic [7:0] v);
        hex_text.push_back(HEX_DIGITS[v[7:4]]);
        hex_text.push_back(HEX_DIGITS[v[3:0]]);
    endfunction

    function automatic void put_eol();
        hex_text.push_back({1'b0, CH_CR});
        hex_text.push_back({1'b0, CH_LF});
    endfunction

    function automatic void encode_item(input logic op, input logic [7:0] b, input logic ce);
        logic [31:0] old_addr;
        logic [15:0] hi;
        logic [7:0]  csum;
        hex_text.delete();
        if (op == OP_DATA)
        begin
            if (rec_fill < MAX_REC)
            begin
                rec_buf[rec_fill] = b;
                rec_fill = rec_fill + 6'd1;
                rec_sum = rec_sum + b;
            end
            if (rec_fill >= size_limit() || ce)
            begin
                old_addr = rec_addr;
                hex_text.push_back({1'b0, CH_COLON});
                put_hex({2'b00, rec_fill});
                put_hex(old_addr[15:8]);
                put_hex(old_addr[7:0]);
                put_hex(REC_TYPE_DATA);
                for (int i = 0; i < rec_fill; i++)
                begin
                    put_hex(rec_buf[i]);
                end
                csum = {2'b00, rec_fill} + old_addr[15:8] + old_addr[7:0] + rec_sum;
                put_hex(8'h00 - csum);
                put_eol();
                rec_addr = old_addr + {26'd0, rec_fill};
                rec_fill = '0;
                rec_sum = '0;
                if (old_addr[31:16] != rec_addr[31:16])
                begin
                    hi = rec_addr[31:16];
                    csum = EXT_LEN + REC_TYPE_EXT + hi[15:8] + hi[7:0];
                    hex_text.push_back({1'b0, CH_COLON});
                    put_hex(EXT_LEN);
                    put_hex(8'h00);
                    put_hex(8'h00);
                    put_hex(REC_TYPE_EXT);
                    put_hex(hi[15:8]);
                    put_hex(hi[7:0]);
                    put_hex(8'h00 - csum);
                    put_eol();
                end
            end
        end
        else
        begin
            rec_fill = '0;
            rec_sum = '0;
            hex_text.push_back({1'b0, CH_COLON});
            put_hex(8'h00);
            put_hex(8'h00);
            put_hex(8'h00);
            put_hex(REC_TYPE_EOF);
            put_hex(EOF_CSUM);
            put_eol();
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one transaction; valid stays up on return, so back-to-back items drop it only in
    // the random idle gaps. A non-empty line overrides the predicted text.
    task automatic push_item(input logic op, input logic [7:0] b, input logic ce,
                             input string line);
        hex_pair_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        s_tlast  <= ce;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        encode_item(op, b, ce);
        if (line.len() != 0)
        begin
            hex_text.delete();
            for (int k = 0; k < line.len(); k++)
            begin
                hex_text.push_back(line[k]);
            end
            put_eol();
        end
        for (int i = 0; i < hex_text.size(); i += 2)
        begin
            p.first = hex_text[i][6:0];
            if (i + 1 < hex_text.size())
            begin
                p.second = hex_text[i + 1][6:0];
                p.cnt = 2'd2;
            end
            else
            begin
                p.second = 7'd0;
                p.cnt = 2'd1;
            end
            p.last = (i + 2 >= hex_text.size());
            pending_pairs.push_back(p);
        end
    endtask

    // Register writes only once the output side has drained and the block is idle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START_ADDRESS)
        begin
            cfg_start = value;
            rec_addr = value;
        end
        else
        begin
            cfg_rec_bytes = value[5:0];
        end
    endtask

    always @(posedge clk)
    begin : rx
        hex_pair_t got;
        hex_pair_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.first  = m_tdata[6:0];
                got.second = m_tdata[13:7];
                got.cnt    = m_tdata[15:14];
                got.last   = m_tlast;
                pairs_checked++;
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction first=%h second=%h cnt=%0d last=%b",
                             $realtime, got.first, got.second, got.cnt, got.last);
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected first=%h second=%h cnt=%0d last=%b",
                                 $realtime, want.first, want.second, want.cnt, want.last);
                        $display("%0t:          actual first=%h second=%h cnt=%0d last=%b",
                                 $realtime, got.first, got.second, got.cnt, got.last);
                    end
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stim
        int          budget;
        int          sent;
        int          n;
        int          roll;
        logic [31:0] start_val;
        logic [5:0]  size_val;

        dir_rows = '{
            '{ROW_ITEM,      OP_DATA, 8'h00, 1'b1, 32'h0, ":0100000000FF"},
            '{ROW_ITEM,      OP_DATA, 8'hFF, 1'b1, 32'h0, ":01000100FFFF"},
            '{ROW_ITEM,      OP_DATA, 8'hA5, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_EOF,  8'h5A, 1'b1, 32'h0, ":00000001FF"},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h3C, 1'b0, 32'h0, ""},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd63, ""},
            '{ROW_ITEM,      OP_DATA, 8'h12, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h34, 1'b1, 32'h0, ""},
            '{ROW_SET_START, OP_DATA, 8'h00, 1'b0, 32'hFFFF_FFFE, ""},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd4, ""},
            '{ROW_ITEM,      OP_DATA, 8'h01, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h02, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h03, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h04, 1'b0, 32'h0, ""},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd8, ""},
            '{ROW_ITEM,      OP_DATA, 8'h80, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h7F, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h55, 1'b0, 32'h0, ""},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd2, ""},
            '{ROW_ITEM,      OP_DATA, 8'hAA, 1'b0, 32'h0, ""},
            '{ROW_SET_START, OP_DATA, 8'h00, 1'b0, 32'h0001_FFFF, ""},
            '{ROW_SET_SIZE,  OP_DATA, 8'h00, 1'b0, 32'd32, ""},
            '{ROW_ITEM,      OP_DATA, 8'h0F, 1'b1, 32'h0, ""},
            '{ROW_ITEM,      OP_DATA, 8'h00, 1'b0, 32'h0, ""},
            '{ROW_ITEM,      OP_EOF,  8'h00, 1'b0, 32'h0, ":00000001FF"}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            case (dir_rows[r].kind)
                ROW_ITEM:
                    push_item(dir_rows[r].op, dir_rows[r].b, dir_rows[r].ce, dir_rows[r].line);
                ROW_SET_START:
                    write_reg(REG_START_ADDRESS, dir_rows[r].val);
                default:
                    write_reg(REG_RECORD_BYTES, dir_rows[r].val);
            endcase
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 63 : 0;
            rcv_idle_pct  = (ph == 0) ? 63 : (ph == 1) ? 12 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                case ($urandom_range(0, 4))
                    0: start_val = 32'h0;
                    1: start_val = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
                    2: start_val = {16'($urandom_range(0, 65535)),
                                    16'(16'hFFFF - $urandom_range(0, 40))};
                    default: start_val = $urandom();
                endcase
                case ($urandom_range(0, 4))
                    0: size_val = 6'd0;
                    1: size_val = 6'($urandom_range(33, 63));
                    2: size_val = 6'd32;
                    default: size_val = 6'($urandom_range(1, 8));
                endcase
                if (ph == 0 && seg == 0)
                begin
                    start_val = 32'hFFFF_FFFF;
                    size_val = 6'd1;
                end
                if (ph == 2 && seg == 0)
                begin
                    size_val = 6'd2;
                end
                write_reg(REG_START_ADDRESS, start_val);
                write_reg(REG_RECORD_BYTES, {26'd0, size_val});
                budget = 5;
                if (ph == 2 && seg == 0)
                begin
                    // long output stall while input keeps coming
                    hold_go <= 1'b1;
                    budget = 20;
                end
                sent = 0;
                while (sent < budget)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                    begin
                        push_item(1'($urandom_range(0, 1)), rand_byte(),
                                  1'($urandom_range(0, 1)), "");
                        sent++;
                    end
                    else if (roll < 18)
                    begin
                        n = $urandom_range(1, 3);
                        repeat (n) push_item(OP_DATA, rand_byte(), 1'b0, "");
                        push_item(OP_EOF, rand_byte(), 1'($urandom_range(0, 1)), "");
                        sent += n + 1;
                    end
                    else
                    begin
                        n = $urandom_range(1, size_limit() + 2);
                        for (int j = 0; j < n; j++)
                        begin
                            push_item(OP_DATA, rand_byte(), (j == n - 1), "");
                        end
                        sent += n;
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);

        $display("Sent %0d input transactions, checked %0d output transactions", items_sent,
                 pairs_checked);
        $display("Covered record sizes 0..63, address wrap, 64K crossings, EOF and stalls");
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ihre_pkg.sv
design/ihre_front.sv
design/ihre_queue.sv
design/ihre_back.sv
design/ihre_pack.sv
design/intel_hex_record_encoder_top.sv
design/ihre_checker.sv
tb/intel_hex_record_encoder_top_tb.sv
